// ----- hw/rtl/kts_pkg.sv -----
// Shared types and constants of the k-nomial tree schedule block.
package kts_pkg;

  // Radix register and base-k digit handling.
  localparam int RADIX_W   = 5;
  localparam int MAX_RADIX = 16;
  localparam int DIGIT_W   = $clog2(MAX_RADIX);
  localparam int BIT_W     = $clog2(DIGIT_W);
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd4;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(MAX_RADIX);

  // Width of the result sideband: action, then level_end.
  localparam int OUT_USER_W = 3;

  // Kind of one schedule result.
  typedef enum logic [1:0] {
    ACT_RECV    = 2'd0,
    ACT_SEND    = 2'd1,
    ACT_NONE    = 2'd2,
    ACT_INVALID = 2'd3
  } action_t;

  // Operations of the shared arithmetic unit.
  typedef enum logic [2:0] {
    ALU_MUL,
    ALU_ADD,
    ALU_ADDW,
    ALU_SUB,
    ALU_RELW
  } alu_op_t;

  // Flags that travel with one result.
  typedef struct packed {
    action_t action;
    logic    level_end;
    logic    last;
  } res_flags_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_REL,
    S_POW,
    S_DIG,
    S_PAR_SUB,
    S_PAR_ADD,
    S_PAR_EMIT,
    S_LVL,
    S_DST,
    S_NXT
  } state_t;

endpackage

// ----- hw/rtl/kts_alu.sv -----
// Shared arithmetic unit: multiply by radix, add, wrapped add, subtract, wrapped subtract.
module kts_alu #(
  parameter int RANK_W = 12,
  localparam int P_W = RANK_W + 5
) (
  input  kts_pkg::alu_op_t              op,
  input  logic [P_W-1:0]                a,
  input  logic [P_W-1:0]                b,
  input  logic [RANK_W:0]               size,
  input  logic [kts_pkg::RADIX_W-1:0]   k,
  output logic [P_W-1:0]                res,
  output logic                          flag
);
  import kts_pkg::*;

  localparam int PROD_W = P_W + RADIX_W;

  logic [P_W:0]    sum;
  logic [P_W:0]    dif;
  logic [P_W:0]    size_x;
  logic [PROD_W-1:0] prod;

  // One operation per cycle; flag meaning depends on the operation.
  always_comb begin
    size_x = (P_W+1)'(size);
    sum    = {1'b0, a} + {1'b0, b};
    dif    = {1'b0, a} - {1'b0, b};
    prod   = PROD_W'(a) * PROD_W'(k);
    res    = '0;
    flag   = 1'b0;
    case (op)
      ALU_MUL: begin
        res  = prod[P_W-1:0];
        flag = ({1'b0, a} >= size_x);
      end
      ALU_ADD: begin
        res  = sum[P_W-1:0];
        flag = (sum >= size_x);
      end
      ALU_ADDW: begin
        flag = (sum >= size_x);
        res  = flag ? P_W'(sum - size_x) : sum[P_W-1:0];
      end
      ALU_SUB: begin
        res  = dif[P_W-1:0];
        flag = dif[P_W];
      end
      ALU_RELW: begin
        flag = dif[P_W];
        res  = flag ? P_W'(dif + size_x) : dif[P_W-1:0];
      end
      default: begin
        res  = '0;
        flag = 1'b0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/kts_out_stage.sv -----
// Output register stage that holds one result until the sink takes it.
module kts_out_stage #(
  parameter int RANK_W = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic [RANK_W-1:0]   peer,
  input  kts_pkg::res_flags_t flags,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [RANK_W-1:0]   out_peer,
  output kts_pkg::res_flags_t out_flags
);
  import kts_pkg::*;

  logic               valid_r;
  logic [RANK_W-1:0]  peer_r;
  res_flags_t         flags_r;

  // The slot can take a new result when empty or when it drains now.
  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_peer  = peer_r;
  assign out_flags = flags_r;

  // Valid flag of the slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Payload of the slot.
  always_ff @(posedge clk) begin
    if (load) begin
      peer_r  <= peer;
      flags_r <= flags;
    end
  end

endmodule

// ----- hw/rtl/knomial_tree_schedule.sv -----
// Top level of the k-nomial tree broadcast schedule generator.
// Each input transaction carries a member rank, the root rank and the group size; the block
// answers with that member's broadcast schedule under the radix k held in the configuration
// register (values below 2 act as 2, above 16 as 16): first the receive from the parent unless
// the member is the root, then the child sends from the highest level down, with level_end on
// the last send of each level and tlast on the final result. Bad input gives one invalid
// result, a one-member group one no-transfer result. All arithmetic runs through one shared
// unit, one operation per cycle while the sink does not stall the output, under a sequencer,
// and the block takes no new input until the schedule is done.
module knomial_tree_schedule #(
  parameter int MAX_RANKS = 4096,
  localparam int RANK_W = $clog2(MAX_RANKS),
  localparam int SIZE_W = RANK_W + 1,
  localparam int IN_W   = ((3 * RANK_W + 1 + 7) / 8) * 8,
  localparam int OUT_W  = ((RANK_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [kts_pkg::RADIX_W-1:0]     cfg_wr_data,  // radix
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [IN_W-1:0]                 in_tdata,     // member_rank, root_rank, group_size
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [OUT_W-1:0]                out_tdata,    // peer_rank
  output logic [kts_pkg::OUT_USER_W-1:0]  out_tuser,    // action, level_end
  output logic                            out_tlast     // last
);
  import kts_pkg::*;

  localparam int P_W   = RANK_W + 5;
  localparam int DEPTH = RANK_W + 1;
  localparam int LVL_W = $clog2(DEPTH);

  // Highest bit of a base-k digit, i.e. bit length of k-1 minus one.
  function automatic logic [BIT_W-1:0] digit_top(input logic [RADIX_W-1:0] k);
    logic [RADIX_W-1:0] km1;
    begin
      km1 = k - RADIX_W'(1);
      if (km1[3]) begin
        digit_top = BIT_W'(3);
      end else if (km1[2]) begin
        digit_top = BIT_W'(2);
      end else if (km1[1]) begin
        digit_top = BIT_W'(1);
      end else begin
        digit_top = '0;
      end
    end
  endfunction

  state_t               state_r, state_nxt;
  logic [RADIX_W-1:0]   radix_r;
  logic [RADIX_W-1:0]   k_r, k_nxt, k_clamp;
  logic [RANK_W-1:0]    rank_r, rank_nxt;
  logic [RANK_W-1:0]    root_r, root_nxt;
  logic [SIZE_W-1:0]    size_r, size_nxt;
  logic [RANK_W-1:0]    rel_r, rel_nxt;
  logic [RANK_W-1:0]    r_r, r_nxt;
  logic [RANK_W-1:0]    rs_r, rs_nxt;
  logic [RANK_W-1:0]    par_r, par_nxt;
  logic [P_W-1:0]       cur_p_r, cur_p_nxt;
  logic [RANK_W-1:0]    pow_r [DEPTH];
  logic                 pow_we;
  logic [LVL_W-1:0]     lvl_r, lvl_nxt;
  logic [BIT_W-1:0]     bit_r, bit_nxt;
  logic [RADIX_W-1:0]   j_r, j_nxt;
  logic [RANK_W-1:0]    crel_r, crel_nxt;
  logic [RANK_W-1:0]    cdst_r, cdst_nxt;

  logic [BIT_W-1:0]     kbit;
  logic [RANK_W-1:0]    mask;
  logic [RANK_W-1:0]    r_new;
  logic                 has_next;
  logic                 plast;
  logic                 bad_in;
  logic                 single;

  alu_op_t              alu_op;
  logic [P_W-1:0]       alu_a, alu_b, alu_res;
  logic                 alu_flag;

  logic                 res_load, res_free;
  logic [RANK_W-1:0]    res_peer;
  res_flags_t           res_flags, out_flags;
  logic [RANK_W-1:0]    out_peer;

  // Radix clamp and digit width.
  assign k_clamp = (radix_r < RADIX_MIN) ? RADIX_MIN :
                   ((radix_r > RADIX_MAX) ? RADIX_MAX : radix_r);
  assign kbit    = digit_top(k_r);
  assign mask    = pow_r[lvl_r];

  // Input checks.
  assign bad_in = (size_r == '0) || (size_r > SIZE_W'(MAX_RANKS)) ||
                  ({1'b0, rank_r} >= size_r) || ({1'b0, root_r} >= size_r);
  assign single = (size_r == SIZE_W'(1));

  assign in_tready = (state_r == S_IDLE);

  // Shared arithmetic unit.
  kts_alu #(.RANK_W(RANK_W)) u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .b    (alu_b),
    .size (size_r),
    .k    (k_r),
    .res  (alu_res),
    .flag (alu_flag)
  );

  // Result register toward the sink.
  kts_out_stage #(.RANK_W(RANK_W)) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_load),
    .peer      (res_peer),
    .flags     (res_flags),
    .free      (res_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_peer  (out_peer),
    .out_flags (out_flags)
  );

  assign out_tdata = OUT_W'(out_peer);
  assign out_tuser = {out_flags.level_end, out_flags.action};
  assign out_tlast = out_flags.last;

  // Sequencer: next state, unit operands and result loads.
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    rank_nxt  = rank_r;
    root_nxt  = root_r;
    size_nxt  = size_r;
    rel_nxt   = rel_r;
    r_nxt     = r_r;
    rs_nxt    = rs_r;
    par_nxt   = par_r;
    cur_p_nxt = cur_p_r;
    lvl_nxt   = lvl_r;
    bit_nxt   = bit_r;
    j_nxt     = j_r;
    crel_nxt  = crel_r;
    cdst_nxt  = cdst_r;
    pow_we    = 1'b0;
    alu_op    = ALU_ADD;
    alu_a     = '0;
    alu_b     = '0;
    res_load  = 1'b0;
    res_peer  = '0;
    res_flags = '{action: ACT_INVALID, level_end: 1'b0, last: 1'b1};
    r_new     = alu_flag ? r_r : alu_res[RANK_W-1:0];
    has_next  = !alu_flag && ((j_r + RADIX_W'(1)) < k_r);
    plast     = alu_flag || (lvl_r == '0);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          rank_nxt  = in_tdata[RANK_W-1:0];
          root_nxt  = in_tdata[2*RANK_W-1:RANK_W];
          size_nxt  = in_tdata[3*RANK_W:2*RANK_W];
          k_nxt     = k_clamp;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (bad_in || single) begin
          res_flags.action = bad_in ? ACT_INVALID : ACT_NONE;
          if (res_free) begin
            res_load  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_REL;
        end
      end
      S_REL: begin
        // Rank relative to the root, wrapped into the group.
        alu_op    = ALU_RELW;
        alu_a     = P_W'(rank_r);
        alu_b     = P_W'(root_r);
        rel_nxt   = alu_res[RANK_W-1:0];
        cur_p_nxt = P_W'(1);
        lvl_nxt   = '0;
        state_nxt = S_POW;
      end
      S_POW: begin
        // Powers of k up to the first one at or above the group size.
        alu_op = ALU_MUL;
        alu_a  = cur_p_r;
        if (alu_flag) begin
          lvl_nxt   = lvl_r - LVL_W'(1);
          r_nxt     = rel_r;
          rs_nxt    = rel_r;
          bit_nxt   = kbit;
          state_nxt = (rel_r == '0) ? S_LVL : S_DIG;
        end else begin
          pow_we    = 1'b1;
          cur_p_nxt = alu_res;
          lvl_nxt   = lvl_r + LVL_W'(1);
        end
      end
      S_DIG: begin
        // Restoring digit extraction, top level first, one digit bit a cycle.
        alu_op = ALU_SUB;
        alu_a  = P_W'(r_r);
        alu_b  = P_W'(mask) << bit_r;
        r_nxt  = r_new;
        if (bit_r == '0) begin
          if (r_new == '0) begin
            state_nxt = S_PAR_SUB;
          end else begin
            lvl_nxt = lvl_r - LVL_W'(1);
            rs_nxt  = r_new;
            bit_nxt = kbit;
          end
        end else begin
          bit_nxt = bit_r - BIT_W'(1);
        end
      end
      S_PAR_SUB: begin
        // Clear the lowest nonzero digit.
        alu_op    = ALU_SUB;
        alu_a     = P_W'(rel_r);
        alu_b     = P_W'(rs_r);
        par_nxt   = alu_res[RANK_W-1:0];
        state_nxt = S_PAR_ADD;
      end
      S_PAR_ADD: begin
        alu_op    = ALU_ADDW;
        alu_a     = P_W'(par_r);
        alu_b     = P_W'(root_r);
        par_nxt   = alu_res[RANK_W-1:0];
        state_nxt = S_PAR_EMIT;
      end
      S_PAR_EMIT: begin
        // The member has children only if one fits at the lowest level.
        alu_op    = ALU_ADD;
        alu_a     = P_W'(rel_r);
        alu_b     = P_W'(1);
        res_peer  = par_r;
        res_flags = '{action: ACT_RECV, level_end: 1'b0, last: plast};
        if (res_free) begin
          res_load = 1'b1;
          if (plast) begin
            state_nxt = S_IDLE;
          end else begin
            lvl_nxt   = lvl_r - LVL_W'(1);
            state_nxt = S_LVL;
          end
        end
      end
      S_LVL: begin
        // First child of this level, if it lies inside the group.
        alu_op = ALU_ADD;
        alu_a  = P_W'(rel_r);
        alu_b  = P_W'(mask);
        if (alu_flag) begin
          lvl_nxt = lvl_r - LVL_W'(1);
        end else begin
          crel_nxt  = alu_res[RANK_W-1:0];
          cdst_nxt  = rank_r;
          j_nxt     = RADIX_W'(1);
          state_nxt = S_DST;
        end
      end
      S_DST: begin
        alu_op    = ALU_ADDW;
        alu_a     = P_W'(cdst_r);
        alu_b     = P_W'(mask);
        cdst_nxt  = alu_res[RANK_W-1:0];
        state_nxt = S_NXT;
      end
      S_NXT: begin
        // Look ahead to the next child to mark the end of the level.
        alu_op    = ALU_ADD;
        alu_a     = P_W'(crel_r);
        alu_b     = P_W'(mask);
        res_peer  = cdst_r;
        res_flags = '{action: ACT_SEND, level_end: !has_next,
                      last: !has_next && (lvl_r == '0)};
        if (res_free) begin
          res_load = 1'b1;
          if (has_next) begin
            crel_nxt  = alu_res[RANK_W-1:0];
            j_nxt     = j_r + RADIX_W'(1);
            state_nxt = S_DST;
          end else if (lvl_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            lvl_nxt   = lvl_r - LVL_W'(1);
            state_nxt = S_LVL;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and radix register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      radix_r <= RADIX_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        radix_r <= cfg_wr_data;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    rank_r  <= rank_nxt;
    root_r  <= root_nxt;
    size_r  <= size_nxt;
    rel_r   <= rel_nxt;
    r_r     <= r_nxt;
    rs_r    <= rs_nxt;
    par_r   <= par_nxt;
    cur_p_r <= cur_p_nxt;
    lvl_r   <= lvl_nxt;
    bit_r   <= bit_nxt;
    j_r     <= j_nxt;
    crel_r  <= crel_nxt;
    cdst_r  <= cdst_nxt;
    if (pow_we) begin
      pow_r[lvl_r] <= cur_p_r[RANK_W-1:0];
    end
  end

`ifndef SYNTH
  // No-transfer and invalid results stand alone and carry no peer.
  a_flag_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] == ACT_NONE || out_tuser[1:0] == ACT_INVALID)
    |-> out_tlast && (out_tdata == '0) && !out_tuser[2])
    else $error("no-transfer or invalid result malformed");

  // The final send of a schedule also closes its level.
  a_last_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] == ACT_SEND) && out_tlast |-> out_tuser[2])
    else $error("final send without level end");

  // A receive is never a wait point.
  a_recv_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] == ACT_RECV) |-> !out_tuser[2])
    else $error("receive marked as level end");

  // The digit remainder only shrinks from the relative rank.
  a_dig_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIG) |-> (r_r <= rel_r))
    else $error("digit remainder above relative rank");

  // A child being emitted lies inside the group.
  a_child_in: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DST || state_r == S_NXT) |-> ({1'b0, crel_r} < size_r))
    else $error("child outside the group");
`endif

endmodule

// ----- verif/tb_knomial_tree_schedule.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the k-nomial tree broadcast schedule generator.
module tb_knomial_tree_schedule;
  import kts_pkg::*;

  localparam int RANKS       = 4096;
  localparam int RANK_W      = 12;
  localparam int SIZE_W      = 13;
  localparam int IN_W        = 40;
  localparam int OUT_W       = 16;
  localparam int IDLE_PCT    = 12;
  localparam int SETTLE      = 200;
  localparam int PHASE_ITEMS = 29;
  localparam int LIMIT       = 1000000;

  // One schedule request as it travels on the input stream.
  typedef struct packed {
    logic [SIZE_W-1:0] group_size;
    logic [RANK_W-1:0] root_rank;
    logic [RANK_W-1:0] member_rank;
  } sched_req_t;

  // One step of a broadcast schedule.
  typedef struct packed {
    action_t           action;
    logic [RANK_W-1:0] peer_rank;
    logic              level_end;
    logic              last;
  } sched_step_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [RADIX_W-1:0]    cfg_wr_data = RADIX_RESET;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;

  sched_req_t   request_q[$];
  sched_step_t  step_q[$];
  sched_req_t   shown_req;
  logic [RADIX_W-1:0] radix_copy = RADIX_RESET;
  bit           calm = 1'b0;
  int unsigned  error_cnt = 0;
  int unsigned  cycle_cnt = 0;

  knomial_tree_schedule dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Expand one request into its schedule steps and queue them for checking.
  function automatic void plan_schedule(sched_req_t req);
    sched_step_t steps[$];
    sched_step_t s;
    int unsigned k, rel, mask, span, peer, first, j;
    int unsigned member, root, size;
    member = 32'(req.member_rank);
    root   = 32'(req.root_rank);
    size   = 32'(req.group_size);
    k = 32'(radix_copy);
    if (k < RADIX_MIN) k = 32'(RADIX_MIN);
    if (k > MAX_RADIX) k = MAX_RADIX;
    s = '0;
    s.last = 1'b1;
    if (size == 0 || size > RANKS || member >= size || root >= size) begin
      s.action = ACT_INVALID;
      step_q.push_back(s);
      return;
    end
    if (size == 1) begin
      s.action = ACT_NONE;
      step_q.push_back(s);
      return;
    end
    s.last = 1'b0;
    rel = (member >= root) ? member - root : member + size - root;
    // Climb to the lowest nonzero base-k digit; that level names the parent.
    mask = 1;
    while (mask < size) begin
      span = k * mask;
      if (rel % span != 0) begin
        peer = (rel / span) * span + root;
        if (peer >= size) peer -= size;
        s.action = ACT_RECV;
        s.peer_rank = peer[RANK_W-1:0];
        steps.push_back(s);
        break;
      end
      mask = span;
    end
    mask = mask / k;
    // Children from the highest level down; a level may turn out empty.
    while (mask > 0) begin
      first = steps.size();
      for (j = 1; j < k; j++) begin
        if (rel + mask * j < size) begin
          peer = member + mask * j;
          if (peer >= size) peer -= size;
          s.action = ACT_SEND;
          s.peer_rank = peer[RANK_W-1:0];
          steps.push_back(s);
        end
      end
      if (steps.size() > first) steps[$].level_end = 1'b1;
      mask = mask / k;
    end
    steps[$].last = 1'b1;
    foreach (steps[i]) step_q.push_back(steps[i]);
  endfunction

  // Random request: mostly well-formed, small groups most of the time.
  function automatic sched_req_t random_request();
    sched_req_t req;
    int unsigned sel, size;
    sel = $urandom_range(99);
    req = '0;
    if (sel < 85) begin
      if (sel < 5) size = 1;
      else if (sel < 60) size = $urandom_range(64, 2);
      else size = $urandom_range(RANKS, 65);
      req.group_size  = size[SIZE_W-1:0];
      req.member_rank = RANK_W'($urandom_range(size - 1, 0));
      req.root_rank   = RANK_W'($urandom_range(size - 1, 0));
    end else begin
      req.member_rank = RANK_W'($urandom_range(RANKS - 1, 0));
      req.root_rank   = RANK_W'($urandom_range(RANKS - 1, 0));
      case ($urandom_range(3))
        0: req.group_size = '0;
        1: req.group_size = SIZE_W'($urandom_range(8191, RANKS + 1));
        2: begin
          size = $urandom_range(RANKS - 1, 1);
          req.group_size  = size[SIZE_W-1:0];
          req.member_rank = RANK_W'($urandom_range(RANKS - 1, size));
        end
        default: begin
          size = $urandom_range(RANKS - 1, 1);
          req.group_size = size[SIZE_W-1:0];
          req.root_rank  = RANK_W'($urandom_range(RANKS - 1, size));
        end
      endcase
    end
    return req;
  endfunction

  task automatic queue_request(int unsigned member, int unsigned root, int unsigned size);
    sched_req_t req;
    req.member_rank = member[RANK_W-1:0];
    req.root_rank   = root[RANK_W-1:0];
    req.group_size  = size[SIZE_W-1:0];
    request_q.push_back(req);
  endtask

  // Sender holds off until every queued request has been answered in full.
  task automatic wait_drained();
    @(negedge clk);
    while (request_q.size() != 0 || in_tvalid || step_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_radix(logic [RADIX_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    radix_copy = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Driver: presents queued requests, with random gaps between transactions outside the calm phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) plan_schedule(shown_req);
      if (!in_tvalid || in_tready) begin
        if (request_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          shown_req = request_q.pop_front();
          in_tdata  <= IN_W'(shown_req);
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction against the oldest expected step.
  always @(posedge clk) begin
    sched_step_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (step_q.size() == 0) begin
          error_cnt++;
          if (error_cnt <= 10)
            $display("unexpected result: action %0d peer %0d level_end %0b last %0b",
                     out_tuser[1:0], out_tdata[RANK_W-1:0], out_tuser[2], out_tlast);
        end else begin
          want = step_q.pop_front();
          if (out_tuser[1:0] !== want.action || out_tdata[RANK_W-1:0] !== want.peer_rank ||
              out_tuser[2] !== want.level_end || out_tlast !== want.last) begin
            error_cnt++;
            if (error_cnt <= 10)
              $display("mismatch: expected action %0d peer %0d level_end %0b last %0b, %s",
                       want.action, want.peer_rank, want.level_end, want.last,
                       $sformatf("got action %0d peer %0d level_end %0b last %0b",
                                 out_tuser[1:0], out_tdata[RANK_W-1:0], out_tuser[2],
                                 out_tlast));
          end
        end
      end
      out_tready <= calm || $urandom_range(99) >= IDLE_PCT;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [RADIX_W-1:0] radix_plan [0:8];
    radix_plan = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd3, 5'd8, 5'd5};
    radix_plan[8] = RADIX_W'($urandom_range(MAX_RADIX, 2));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed cases under the reset radix.
    queue_request(0, 0, 1);           // single member
    queue_request(0, 0, 0);           // empty group
    queue_request(0, 0, RANKS + 1);   // group too large
    queue_request(4095, 4095, 8191);  // all fields at their top
    queue_request(5, 0, 5);           // member outside the group
    queue_request(0, 7, 7);           // root outside the group
    queue_request(0, 0, RANKS);       // root of the largest group
    queue_request(4095, 0, RANKS);    // leaf of the largest group
    queue_request(0, 4095, RANKS);    // ranks wrap past the end
    queue_request(4095, 4095, RANKS);
    queue_request(2048, 0, RANKS);
    queue_request(0, 0, 2);
    queue_request(1, 0, 2);
    queue_request(1, 0, 6);           // leaf with only its receive
    queue_request(4, 0, 5);           // level with no child in range
    queue_request(4, 0, 6);           // partly filled level
    queue_request(2, 2, 5);           // nonzero root, children wrap
    queue_request(3, 2, 5);
    queue_request(0, 3, 17);
    queue_request(16, 0, 64);
    wait_drained();

    // Random phases, each under its own radix setting.
    foreach (radix_plan[p]) begin
      write_radix(radix_plan[p]);
      calm = (p == 3);
      queue_request(0, 0, RANKS);
      queue_request(RANKS - 1, 1, RANKS);
      repeat (PHASE_ITEMS) request_q.push_back(random_request());
      wait_drained();
    end
    calm = 1'b0;

    if (step_q.size() != 0) error_cnt += step_q.size();
    if (error_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/kts_pkg.sv
hw/rtl/kts_alu.sv
hw/rtl/kts_out_stage.sv
hw/rtl/knomial_tree_schedule.sv
verif/tb_knomial_tree_schedule.sv
